// ===== hw/rtl/aarm_pkg.sv =====
package aarm_pkg;

  localparam int CordicIters = 24;
  localparam logic signed [33:0] CordicKQ30 = 34'sd652032874;
  localparam logic signed [33:0] PiQ24 = 34'sd52707179;
  localparam logic signed [33:0] HalfPiQ24 = 34'sd26353589;

  // stages: 0 reduce, 1..24 cordic, 25 round, 26 products, 27 squares,
  // 28 sum, 29..59 sqrt, 60..90 divide, 91 products, 92 sums, 93 output
  localparam int SqS = 31;
  localparam int DvS = 31;
  localparam int CS = 1 + CordicIters;
  localparam int QS = CS + 1;
  localparam int PS = QS + 1;
  localparam int SS = PS + 1;
  localparam int RS = SS + 1;
  localparam int DS = RS + SqS;
  localparam int MS = DS + DvS;
  localparam int Depth = MS + 3;

  function automatic logic signed [33:0] atan_entry(input int i);
    logic signed [33:0] r;
    begin
      case (i)
        0: r = 34'sd13176795;
        1: r = 34'sd7778716;
        2: r = 34'sd4110060;
        3: r = 34'sd2086331;
        4: r = 34'sd1047214;
        5: r = 34'sd524117;
        6: r = 34'sd262123;
        7: r = 34'sd131069;
        default: r = 34'sd1 <<< (24 - i);
      endcase
      return r;
    end
  endfunction

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic flip;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
  } cordic_t;

  typedef struct packed {
    logic [59:0] rem;
    logic [30:0] root;
  } sqrt_t;

endpackage

// ===== hw/rtl/aarm_pipe_ctl.sv =====
module aarm_pipe_ctl import aarm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output logic [Depth-1:0] vld,
  output logic [Depth-1:0] adv
);
  // Per-stage valid bits; a stage advances when its successor frees up.
  always_comb begin
    adv[Depth-1] = !vld[Depth-1] || out_ready;
    for (int i = Depth - 2; i >= 0; i--) adv[i] = !vld[i] || adv[i+1];
  end
  assign in_ready = adv[0];
  assign out_valid = vld[Depth-1];
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= in_valid;
      for (int i = 1; i < Depth; i++) if (adv[i]) vld[i] <= vld[i-1];
    end
  end
endmodule

// ===== hw/rtl/axis_angle_to_rotation_matrix.sv =====
// Axis-angle to rotation matrix. Forms the quaternion (cos(a/2), axis*sin(a/2))
// with a 24-step CORDIC, normalizes it by its length (pipelined square root
// and restoring divides), and returns the nine Q2.14 entries, saturated.
// Zero length gives the identity with degenerate set. Fully pipelined: one
// transaction per cycle while out_ready holds, through one-step-per-stage
// CORDIC, square root and divider chains. A stall holds only the stages
// backed up behind it; empty stages keep filling.
module axis_angle_to_rotation_matrix import aarm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [15:0] turn_angle,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [15:0] m00,
  output logic signed [15:0] m01,
  output logic signed [15:0] m02,
  output logic signed [15:0] m10,
  output logic signed [15:0] m11,
  output logic signed [15:0] m12,
  output logic signed [15:0] m20,
  output logic signed [15:0] m21,
  output logic signed [15:0] m22,
  output logic degenerate
);
  logic [Depth-1:0] vld, adv;
  aarm_pipe_ctl u_ctl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .vld, .adv
  );

  cordic_t cr [CS];
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      logic signed [33:0] z;
      logic flip;
      z = 34'(turn_angle) <<< 11;
      flip = 1'b0;
      if (z > HalfPiQ24) begin
        z = z - PiQ24;
        flip = 1'b1;
      end else if (z < -HalfPiQ24) begin
        z = z + PiQ24;
        flip = 1'b1;
      end
      cr[0].flip <= flip;
      cr[0].z <= z;
      cr[0].x <= CordicKQ30;
      cr[0].y <= '0;
      cr[0].ax <= axis_x;
      cr[0].ay <= axis_y;
      cr[0].az <= axis_z;
    end
  end
  for (genvar g = 0; g < CordicIters; g++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (adv[g+1]) begin
        cordic_t nx;
        nx = cr[g];
        if (cr[g].z >= 0) begin
          nx.x = cr[g].x - (cr[g].y >>> g);
          nx.y = cr[g].y + (cr[g].x >>> g);
          nx.z = cr[g].z - atan_entry(g);
        end else begin
          nx.x = cr[g].x + (cr[g].y >>> g);
          nx.y = cr[g].y - (cr[g].x >>> g);
          nx.z = cr[g].z + atan_entry(g);
        end
        cr[g+1] <= nx;
      end
    end
  end

  logic signed [17:0] cs, sn;
  logic signed [15:0] ax1, ay1, az1;
  always_ff @(posedge clk) begin
    if (adv[CS]) begin
      logic signed [33:0] xf, yf;
      xf = cr[CS-1].flip ? -cr[CS-1].x : cr[CS-1].x;
      yf = cr[CS-1].flip ? -cr[CS-1].y : cr[CS-1].y;
      cs <= 18'((xf + 34'sd32768) >>> 16);
      sn <= 18'((yf + 34'sd32768) >>> 16);
      ax1 <= cr[CS-1].ax;
      ay1 <= cr[CS-1].ay;
      az1 <= cr[CS-1].az;
    end
  end

  logic signed [33:0] qv [4];
  always_ff @(posedge clk) begin
    if (adv[QS]) begin
      qv[0] <= 34'(cs) <<< 14;
      qv[1] <= 34'(ax1) * 34'(sn);
      qv[2] <= 34'(ay1) * 34'(sn);
      qv[3] <= 34'(az1) * 34'(sn);
    end
  end

  logic [59:0] sq [4];
  logic signed [33:0] qv2 [4];
  always_ff @(posedge clk) begin
    if (adv[PS]) begin
      for (int k = 0; k < 4; k++) begin
        logic [32:0] m;
        m = qv[k][33] ? 33'(-qv[k]) : 33'(qv[k]);
        sq[k] <= 60'(m) * 60'(m);
        qv2[k] <= qv[k];
      end
    end
  end

  sqrt_t sr [SqS+1];
  logic [61:0] l2;
  logic signed [33:0] qd [SqS+1][4];
  always_ff @(posedge clk) begin
    if (adv[SS]) begin
      l2 <= 62'(sq[0]) + 62'(sq[1]) + 62'(sq[2]) + 62'(sq[3]);
      qd[0] <= qv2;
    end
  end
  // square root: one result bit per stage, bit pair from the top
  always_comb begin
    sr[0].rem = '0;
    sr[0].root = '0;
  end
  logic [61:0] l2p [SqS+1];
  assign l2p[0] = l2;
  for (genvar g = 0; g < SqS; g++) begin : g_sqrt
    logic [62:0] trial;
    logic [62:0] rem_sh;
    always_comb begin
      rem_sh = {1'b0, sr[g].rem, l2p[g][61:60]};
      trial = rem_sh - {30'd0, sr[g].root, 2'b01};
    end
    always_ff @(posedge clk) begin
      if (adv[RS+g]) begin
        l2p[g+1] <= l2p[g] << 2;
        qd[g+1] <= qd[g];
        if (!trial[62]) begin
          sr[g+1].rem <= 60'(trial);
          sr[g+1].root <= {sr[g].root[29:0], 1'b1};
        end else begin
          sr[g+1].rem <= 60'(rem_sh);
          sr[g+1].root <= {sr[g].root[29:0], 1'b0};
        end
      end
    end
  end

  logic [30:0] len;
  assign len = sr[SqS].root;
  // four dividers: |v|<<30 / len, one quotient bit per stage
  // |v| < 2^33, quotient < 2^31 since |v| <= len
  logic [30:0] dlen [DvS+1];
  logic [30:0] dq [DvS+1][4];
  logic [31:0] drem [DvS+1][4];
  logic [30:0] dbits [DvS+1][4];
  logic dneg [DvS+1][4];
  logic [32:0] dnum [4];
  logic [62:0] dfull [4];
  logic [31:0] dpre [4];
  // the upper 32 bits are < 2*len... reduce first with one compare
  always_comb begin
    dlen[0] = len;
    for (int k = 0; k < 4; k++) begin
      dneg[0][k] = qd[SqS][k][33];
      dnum[k] = dneg[0][k] ? 33'(-qd[SqS][k]) : 33'(qd[SqS][k]);
      dfull[k] = {dnum[k], 30'd0};
      dpre[k] = dfull[k][62:31];
      drem[0][k] = (dpre[k] >= {1'b0, len}) ? dpre[k] - {1'b0, len} : dpre[k];
      dbits[0][k] = dfull[k][30:0];
      dq[0][k] = '0;
    end
  end
  for (genvar g = 0; g < DvS; g++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv[DS+g]) begin
        dlen[g+1] <= dlen[g];
        for (int k = 0; k < 4; k++) begin
          logic [32:0] t;
          t = {drem[g][k], dbits[g][k][30]} - {2'b0, dlen[g]};
          dneg[g+1][k] <= dneg[g][k];
          dbits[g+1][k] <= dbits[g][k] << 1;
          if (!t[32]) begin
            drem[g+1][k] <= 32'(t);
            dq[g+1][k] <= {dq[g][k][29:0], 1'b1};
          end else begin
            drem[g+1][k] <= {drem[g][k][30:0], dbits[g][k][30]};
            dq[g+1][k] <= {dq[g][k][29:0], 1'b0};
          end
        end
      end
    end
  end
  // carry the zero flag along the divide stages
  logic dz [DvS+1];
  assign dz[0] = (len == '0);
  for (genvar g = 0; g < DvS; g++) begin : g_dz
    always_ff @(posedge clk) if (adv[DS+g]) dz[g+1] <= dz[g];
  end

  logic signed [31:0] nq [4];
  always_comb begin
    for (int k = 0; k < 4; k++)
      nq[k] = dneg[DvS][k] ? -$signed({1'b0, dq[DvS][k]}) : $signed({1'b0, dq[DvS][k]});
  end

  // products in Q.60
  logic signed [63:0] pr [1:9];
  logic pz;
  always_ff @(posedge clk) begin
    if (adv[MS]) begin
      pz <= dz[DvS];
      pr[1] <= 64'(nq[1]) * 64'(nq[1]);
      pr[2] <= 64'(nq[2]) * 64'(nq[2]);
      pr[3] <= 64'(nq[3]) * 64'(nq[3]);
      pr[4] <= 64'(nq[1]) * 64'(nq[2]);
      pr[5] <= 64'(nq[0]) * 64'(nq[3]);
      pr[6] <= 64'(nq[1]) * 64'(nq[3]);
      pr[7] <= 64'(nq[0]) * 64'(nq[2]);
      pr[8] <= 64'(nq[2]) * 64'(nq[3]);
      pr[9] <= 64'(nq[0]) * 64'(nq[1]);
    end
  end
  // q = s a b c -> idx 0 1 2 3
  logic signed [65:0] e [9];
  logic ez;
  localparam logic signed [65:0] One = 66'sd1 <<< 60;
  always_ff @(posedge clk) begin
    if (adv[MS+1]) begin
      ez <= pz;
      e[0] <= One - 2 * 66'(pr[2]) - 2 * 66'(pr[3]);
      e[1] <= 2 * 66'(pr[4]) - 2 * 66'(pr[5]);
      e[2] <= 2 * 66'(pr[6]) + 2 * 66'(pr[7]);
      e[3] <= 2 * 66'(pr[4]) + 2 * 66'(pr[5]);
      e[4] <= One - 2 * 66'(pr[1]) - 2 * 66'(pr[3]);
      e[5] <= 2 * 66'(pr[8]) - 2 * 66'(pr[9]);
      e[6] <= 2 * 66'(pr[6]) - 2 * 66'(pr[7]);
      e[7] <= 2 * 66'(pr[8]) + 2 * 66'(pr[9]);
      e[8] <= One - 2 * 66'(pr[1]) - 2 * 66'(pr[2]);
    end
  end

  function automatic logic signed [15:0] to_q14(input logic signed [65:0] v);
    logic signed [65:0] r;
    begin
      r = (v + (66'sd1 <<< 45)) >>> 46;
      if (r > 66'sd32767) return 16'sh7fff;
      if (r < -66'sd32768) return 16'sh8000;
      return 16'(r);
    end
  endfunction

  logic signed [15:0] mo [9];
  always_ff @(posedge clk) begin
    if (adv[MS+2]) begin
      degenerate <= ez;
      for (int k = 0; k < 9; k++)
        mo[k] <= ez ? ((k % 4 == 0) ? 16'sd16384 : 16'sd0) : to_q14(e[k]);
    end
  end
  assign m00 = mo[0];
  assign m01 = mo[1];
  assign m02 = mo[2];
  assign m10 = mo[3];
  assign m11 = mo[4];
  assign m12 = mo[5];
  assign m20 = mo[6];
  assign m21 = mo[7];
  assign m22 = mo[8];
endmodule

// ===== tb/axis_angle_to_rotation_matrix_checker.sv =====
module axis_angle_to_rotation_matrix_checker (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  logic signed [15:0] turn_angle,
  input  logic signed [15:0] axis_x,
  input  logic signed [15:0] axis_y,
  input  logic signed [15:0] axis_z,
  input  logic out_valid,
  input  logic out_ready,
  input  logic signed [15:0] m00,
  input  logic signed [15:0] m01,
  input  logic signed [15:0] m02,
  input  logic signed [15:0] m10,
  input  logic signed [15:0] m11,
  input  logic signed [15:0] m12,
  input  logic signed [15:0] m20,
  input  logic signed [15:0] m21,
  input  logic signed [15:0] m22,
  input  logic degenerate,
  output int fail_count,
  output int pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [8:0][15:0] entry;
    logic degen;
  } rotation_t;

  localparam longint KQ30 = 64'sd652032874;
  localparam longint PiQ24 = 64'sd52707179;
  localparam longint HalfPiQ24 = 64'sd26353589;

  rotation_t rotation_q[$];

  function automatic longint arctan_q24(int i);
    case (i)
      0: return 13176795;
      1: return 7778716;
      2: return 4110060;
      3: return 2086331;
      4: return 1047214;
      5: return 524117;
      6: return 262123;
      7: return 131069;
      default: return longint'(1) <<< (24 - i);
    endcase
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unit_q30(longint v, longint unsigned l);
    longint unsigned mag;
    longint q;
    mag = (v < 0) ? longint'(-v) : v;
    q = longint'((mag << 30) / l);
    return (v < 0) ? -q : q;
  endfunction

  function automatic logic [15:0] sat_q14(longint v60);
    longint r;
    r = (v60 + (longint'(1) <<< 45)) >>> 46;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic rotation_t rotate(logic signed [15:0] ang, logic signed [15:0] vx,
                                       logic signed [15:0] vy, logic signed [15:0] vz);
    rotation_t r;
    longint z, x, y, dx, dy, cs, sn, s, a, b, c, qa, qb, qc, qs, one;
    longint unsigned l;
    logic flip;
    z = longint'(ang) * 2048;
    flip = 1'b0;
    x = KQ30;
    y = 0;
    if (z > HalfPiQ24) begin
      z -= PiQ24;
      flip = 1'b1;
    end else if (z < -HalfPiQ24) begin
      z += PiQ24;
      flip = 1'b1;
    end
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= arctan_q24(i);
      end else begin
        x += dx;
        y -= dy;
        z += arctan_q24(i);
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    cs = (x + 32768) >>> 16;
    sn = (y + 32768) >>> 16;
    s = cs * 16384;
    a = longint'(vx) * sn;
    b = longint'(vy) * sn;
    c = longint'(vz) * sn;
    l = root64(a * a + b * b + c * c + s * s);
    r = '0;
    if (l == 0) begin
      r.entry[0] = 16384;
      r.entry[4] = 16384;
      r.entry[8] = 16384;
      r.degen = 1'b1;
      return r;
    end
    qa = unit_q30(a, l);
    qb = unit_q30(b, l);
    qc = unit_q30(c, l);
    qs = unit_q30(s, l);
    one = longint'(1) <<< 60;
    r.entry[0] = sat_q14(one - 2 * qb * qb - 2 * qc * qc);
    r.entry[1] = sat_q14(2 * qa * qb - 2 * qs * qc);
    r.entry[2] = sat_q14(2 * qa * qc + 2 * qs * qb);
    r.entry[3] = sat_q14(2 * qa * qb + 2 * qs * qc);
    r.entry[4] = sat_q14(one - 2 * qa * qa - 2 * qc * qc);
    r.entry[5] = sat_q14(2 * qb * qc - 2 * qs * qa);
    r.entry[6] = sat_q14(2 * qa * qc - 2 * qs * qb);
    r.entry[7] = sat_q14(2 * qb * qc + 2 * qs * qa);
    r.entry[8] = sat_q14(one - 2 * qa * qa - 2 * qb * qb);
    return r;
  endfunction

  string entry_name [9] = '{"m00", "m01", "m02", "m10", "m11", "m12", "m20", "m21", "m22"};

  always @(posedge clk) begin
    rotation_t want;
    logic [8:0][15:0] got;
    if (rst) begin
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) rotation_q.push_back(rotate(turn_angle, axis_x, axis_y, axis_z));
      if (out_valid && out_ready) begin
        got = {m22, m21, m20, m12, m11, m10, m02, m01, m00};
        if (rotation_q.size() == 0) begin
          $error("unexpected output transaction");
          fail_count++;
        end else begin
          want = rotation_q.pop_front();
          for (int k = 0; k < 9; k++)
            if (got[k] !== want.entry[k]) begin
              $error("%s expected %0d actual %0d", entry_name[k],
                     $signed(want.entry[k]), $signed(got[k]));
              fail_count++;
            end
          if (degenerate !== want.degen) begin
            $error("degenerate expected %0d actual %0d", want.degen, degenerate);
            fail_count++;
          end
        end
      end
    end
    pending_count = rotation_q.size();
  end
endmodule

// ===== tb/axis_angle_to_rotation_matrix_tb.sv =====
module axis_angle_to_rotation_matrix_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [15:0] turn_angle = '0;
  logic signed [15:0] axis_x = '0;
  logic signed [15:0] axis_y = '0;
  logic signed [15:0] axis_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  logic degenerate;
  int fail_count, pending_count;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_timer = 0;

  axis_angle_to_rotation_matrix i_dut (.*);
  axis_angle_to_rotation_matrix_checker i_checker (.*);

  initial forever #5 clk = ~clk;

  initial begin
    #5ms;
    $display("FAIL axis_angle_to_rotation_matrix");
    $finish;
  end

  always @(posedge clk) begin
    if (stall_timer == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_timer <= $urandom_range(10, 120);
    end else begin
      stall_timer <= stall_timer - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 9) == 0);
      default: out_ready <= (stall_timer[2:0] != 0);
    endcase
  end

  task automatic send_pose(logic signed [15:0] ang, logic signed [15:0] vx,
                           logic signed [15:0] vy, logic signed [15:0] vz);
    in_valid <= 1'b1;
    turn_angle <= ang;
    axis_x <= vx;
    axis_y <= vy;
    axis_z <= vz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(0, 30);
    end else begin
      burst_left--;
    end
  endtask

  function automatic logic signed [15:0] near_pi();
    logic signed [15:0] v;
    v = 16'sd12868 - 16'($urandom_range(0, 3));
    return ($urandom_range(0, 1) == 1) ? -v : v;
  endfunction

  initial begin
    logic signed [15:0] ang;
    int sel;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_pose(0, 16384, 0, 0);
    send_pose(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_pose(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_pose(16'sh7fff, 16'sh8000, 0, 16'sh7fff);
    send_pose(16'sh8000, 0, 16'sh7fff, 16'sh8000);
    send_pose(6434, 0, 0, 16384);
    send_pose(-6434, 16384, 0, 0);
    send_pose(12868, 0, 16384, 0);
    send_pose(12867, 0, 0, 16384);
    send_pose(-12868, 16384, 16384, 0);
    send_pose(-12867, 16384, 0, 0);
    send_pose(12868, 0, 0, 0);
    send_pose(-12868, 0, 0, 0);
    send_pose(12866, 0, 0, 0);
    send_pose(1000, 0, 0, 0);
    send_pose(-20000, 0, 0, 0);
    send_pose(0, 0, 0, 0);
    send_pose(25736, 9459, 9459, 9459);
    send_pose(3217, 16'sh7fff, 16'sh7fff, 0);
    send_pose(-3217, -1, 1, -1);
    for (int n = 0; n < 1700; n++) begin
      sel = $urandom_range(0, 19);
      ang = (sel == 0) ? near_pi() : 16'($urandom);
      if (sel == 1) send_pose(ang, 0, 0, 0);
      else if (sel < 8) send_pose(ang, 16'($urandom_range(0, 32767) - 16384),
                                  16'($urandom_range(0, 32767) - 16384),
                                  16'($urandom_range(0, 32767) - 16384));
      else send_pose(ang, 16'($urandom), 16'($urandom), 16'($urandom));
    end
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS axis_angle_to_rotation_matrix");
    end else begin
      $display("FAIL axis_angle_to_rotation_matrix");
    end
    $finish;
  end
endmodule
